[sv/lifo_stack_with_search_unit_macros.svh]
`ifndef LIFO_STACK_WITH_SEARCH_UNIT_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define LSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define LSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_TOP    = 2'd2,
        CMD_SEARCH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

endpackage

`default_nettype wire

[sv/lss_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lss_in_if;
    logic                                valid;
    logic                                ready;
    lss_pkg::t_cmd                       cmd;
    logic signed [lss_pkg::DATA_W-1:0]   value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface lss_out_if;
    logic                                valid;
    logic                                ready;
    lss_pkg::t_status                    status;
    logic signed [lss_pkg::DATA_W-1:0]   data;
    logic        [lss_pkg::POS_W-1:0]    position;

    modport source (output valid, output status, output data, output position, input ready);
    modport sink   (input valid, input status, input data, input position, output ready);
endinterface

`default_nettype wire

[sv/lifo_stack_with_search_unit.sv]
// Push goes through S_DONE to the output register; pop and top add S_READ for
// the one registered memory read; search compares entries top down in S_SEARCH
// before S_DONE. One transaction at a time; search walks the single memory read
// port one entry per cycle.
// Reset (i_rst_n, synchronous, active low) empties the stack and the output
// register; the stack memory keeps its contents and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "lifo_stack_with_search_unit_macros.svh"

module lifo_stack_with_search_unit #(
    parameter int DEPTH = 64
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    lss_in_if.sink        i_cmd_ch,
    lss_out_if.source     o_res_ch
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = lss_pkg::DATA_W;
    localparam int PW = lss_pkg::POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEARCH,
        S_DONE
    } t_state;

    // stack memory, one write and one registered read port
    logic signed [DW-1:0] r_mem [DEPTH];
    logic signed [DW-1:0] r_rd_data;

    t_state               r_state,      n_state;
    logic [CW-1:0]        r_count,      n_count;
    logic [AW-1:0]        r_addr,       n_addr;
    logic [CW-1:0]        r_pos,        n_pos;
    logic signed [DW-1:0] r_key,        n_key;
    lss_pkg::t_status     r_res_status, n_res_status;
    logic signed [DW-1:0] r_res_data,   n_res_data;
    logic [CW-1:0]        r_res_pos,    n_res_pos;
    logic                 r_o_valid,    n_o_valid;
    lss_pkg::t_status     r_o_status,   n_o_status;
    logic signed [DW-1:0] r_o_data,     n_o_data;
    logic [PW-1:0]        r_o_pos,      n_o_pos;

    logic                 in_accept;
    logic                 is_full;
    logic                 is_empty;
    logic [AW-1:0]        top_addr;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;

    assign i_cmd_ch.ready    = (r_state == S_IDLE);
    assign in_accept         = i_cmd_ch.valid && (r_state == S_IDLE);
    assign is_full           = (r_count == CW'(DEPTH));
    assign is_empty          = (r_count == '0);
    assign top_addr          = AW'(r_count - 1'b1);

    assign o_res_ch.valid    = r_o_valid;
    assign o_res_ch.status   = r_o_status;
    assign o_res_ch.data     = r_o_data;
    assign o_res_ch.position = r_o_pos;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_pos        = r_pos;
        n_key        = r_key;
        n_res_status = r_res_status;
        n_res_data   = r_res_data;
        n_res_pos    = r_res_pos;
        n_o_valid    = r_o_valid;
        n_o_status   = r_o_status;
        n_o_data     = r_o_data;
        n_o_pos      = r_o_pos;
        rd_en        = 1'b0;
        rd_addr      = top_addr;
        wr_en        = 1'b0;

        // drop the result once the sink takes it
        if (r_o_valid && o_res_ch.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_res_status = lss_pkg::ST_OK;
                    n_res_data   = '0;
                    n_res_pos    = '0;
                    n_state      = S_DONE;
                    case (i_cmd_ch.cmd)
                        lss_pkg::CMD_PUSH: begin
                            if (is_full) begin
                                n_res_status = lss_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        lss_pkg::CMD_POP: begin
                            if (is_empty) begin
                                n_res_status = lss_pkg::ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_count = r_count - 1'b1;
                                n_state = S_READ;
                            end
                        end
                        lss_pkg::CMD_TOP: begin
                            if (is_empty) begin
                                n_res_status = lss_pkg::ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = S_READ;
                            end
                        end
                        lss_pkg::CMD_SEARCH: begin
                            if (is_empty) begin
                                n_res_status = lss_pkg::ST_EMPTY;
                            end else begin
                                // start at the top, position 1
                                rd_en   = 1'b1;
                                n_addr  = top_addr;
                                n_pos   = CW'(1);
                                n_key   = i_cmd_ch.value;
                                n_state = S_SEARCH;
                            end
                        end
                        default: begin
                            n_res_status = lss_pkg::ST_EMPTY;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res_data = r_rd_data;
                n_state    = S_DONE;
            end
            S_SEARCH: begin
                if (r_rd_data == r_key) begin
                    n_res_pos = r_pos;
                    n_state   = S_DONE;
                end else if (r_addr == '0) begin
                    n_res_status = lss_pkg::ST_NOTFOUND;
                    n_state      = S_DONE;
                end else begin
                    // advance one entry toward the bottom
                    rd_en   = 1'b1;
                    rd_addr = r_addr - 1'b1;
                    n_addr  = r_addr - 1'b1;
                    n_pos   = r_pos + 1'b1;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_o_valid || o_res_ch.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_data   = r_res_data;
                    n_o_pos    = PW'(r_res_pos);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= i_cmd_ch.value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_addr       <= n_addr;
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_res_status <= n_res_status;
        r_res_data   <= n_res_data;
        r_res_pos    <= n_res_pos;
        r_o_status   <= n_o_status;
        r_o_data     <= n_o_data;
        r_o_pos      <= n_o_pos;
    end

    `LSS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "entry count above depth")
    `LSS_ASSERT_NEXT(a_push_grows, in_accept && i_cmd_ch.cmd == lss_pkg::CMD_PUSH && !is_full, r_count == $past(r_count) + 1'b1, "push did not grow the stack")
    `LSS_ASSERT_NOW(a_search_walk, r_state == S_SEARCH, (CW+1)'(r_pos) + (CW+1)'(r_addr) == (CW+1)'(r_count), "search position and address out of step")
    `LSS_ASSERT_NOW(a_fail_zero, r_o_valid && r_o_status != lss_pkg::ST_OK, r_o_data == '0 && r_o_pos == '0, "failed transaction carries data")

endmodule

`default_nettype wire
